// ===== rtl/core/wgm_pkg.sv =====
// Shared types and constants for the wildcard glob matcher.
// No dependencies; imported by every module of the block.
package wgm_pkg;

    localparam int unsigned PATTERN_DEPTH_DEF = 128;
    localparam int unsigned SYM_W             = 8;

    localparam logic [SYM_W-1:0] SYM_ANY_ONE = 8'd63;  // '?'
    localparam logic [SYM_W-1:0] SYM_ANY_RUN = 8'd42;  // '*'

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    // Broadcast controls, same for every cell
    typedef struct packed {
        logic             shift;  // pattern byte stored: chain shifts left
        logic             step;   // text byte accepted: advance active set
        logic             rearm;  // reload active set from pattern start
        logic [SYM_W-1:0] sym;    // incoming byte (text or pattern)
    } wgm_ctrl_t;

    // What one cell hands to its right-hand neighbor
    typedef struct packed {
        logic vld;       // cell holds a pattern byte
        logic adv;       // active, non-star byte matches text byte
        logic pre;       // active before star closure (next cycle)
        logic starv;     // holds a star
        logic vld_nx;    // vld after this cycle's load
        logic st_nx;     // is first pattern byte after this cycle's load
        logic starv_nx;  // starv after this cycle's load
    } wgm_link_t;

endpackage

// ===== rtl/core/wildcard_glob_matcher.sv =====
// Wildcard glob matcher: row of pattern cells plus a two-entry result buffer.
// Depends on wgm_pkg, wgm_cell, wgm_out_buf.
// Result: m_tvalid is high in the cycle after the last text byte, but the result may wait behind held results.
// Throughput: one request per cycle, as the active set is updated on every accepted byte;
//   s_tready drops only while both result entries are held.
// Reset: empty pattern, nothing pending; no clearing pass is needed.
module wildcard_glob_matcher
#(
    parameter int unsigned PATTERN_DEPTH = wgm_pkg::PATTERN_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tuser,   // [0] mode: 0 pattern byte, 1 text byte
    input  logic       s_tlast,   // last byte of pattern or of text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [7:1] zero
);
    import wgm_pkg::*;

    localparam int unsigned CNT_W = $clog2(PATTERN_DEPTH + 1);

    // Pattern is kept right-aligned in the cell row: the newest byte sits in
    // the top cell and the accept position is fixed just past it. A run of
    // stars is folded into one on load, so star closure is a one-hop step.
    // raw_cnt counts bytes as received (folded or not) to detect overflow.

    logic [CNT_W-1:0] raw_cnt_reg;
    logic [CNT_W-1:0] raw_cnt_next;
    logic             closed_reg;
    logic             closed_next;
    logic             ovf_reg;
    logic             ovf_next;

    logic             acc;
    logic             pat_acc;
    logic             txt_fin;
    logic             restart;
    logic [CNT_W-1:0] raw_eff;
    logic             room;
    logic             fold;
    logic             end_hit;
    logic             buf_ready;
    logic             buf_data;

    wgm_ctrl_t        ctrl;
    wgm_link_t        links [PATTERN_DEPTH+1];
    logic [SYM_W-1:0] syms  [PATTERN_DEPTH];

    assign acc     = s_tvalid & s_tready;
    assign pat_acc = acc & (s_tuser == MODE_PATTERN);
    assign txt_fin = acc & (s_tuser == MODE_TEXT) & s_tlast;
    assign restart = closed_reg;

    assign raw_eff = restart ? '0 : raw_cnt_reg;
    assign room    = (raw_eff < CNT_W'(PATTERN_DEPTH));
    // a star right after a stored star adds nothing
    assign fold    = (s_tdata == SYM_ANY_RUN) & ~restart & links[PATTERN_DEPTH].starv;

    assign ctrl.shift = pat_acc & room & ~fold;
    assign ctrl.step  = acc & (s_tuser == MODE_TEXT);
    assign ctrl.rearm = pat_acc | txt_fin;
    assign ctrl.sym   = s_tdata;

    assign links[0] = '0;

    genvar p;
    generate
        for (p = 0; p < PATTERN_DEPTH; p++)
        begin : g_cell
            logic [SYM_W-1:0] sym_in;
            logic             vld_in;
            if (p == PATTERN_DEPTH - 1)
            begin : g_top
                assign sym_in = s_tdata;
                assign vld_in = 1'b1;
            end
            else
            begin : g_mid
                assign sym_in = syms[p+1];
                assign vld_in = links[p+2].vld & ~restart;
            end
            wgm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .sym_in    (sym_in),
                .vld_in    (vld_in),
                .prev_link (links[p]),
                .link      (links[p+1]),
                .sym_out   (syms[p])
            );
        end
    endgenerate

    // Accept position: reached by the top cell's advance or star closure
    assign end_hit  = links[PATTERN_DEPTH].adv |
                      (links[PATTERN_DEPTH].pre & links[PATTERN_DEPTH].starv);
    assign buf_data = end_hit & ~ovf_reg;

    always_comb
    begin
        raw_cnt_next = raw_cnt_reg;
        closed_next  = closed_reg;
        ovf_next     = ovf_reg;
        if (pat_acc)
        begin
            raw_cnt_next = room ? raw_eff + CNT_W'(1) : raw_eff;
            ovf_next     = (ovf_reg & ~restart) | ~room;
            closed_next  = s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_cnt_reg <= '0;
            closed_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            raw_cnt_reg <= raw_cnt_next;
            closed_reg  <= closed_next;
            ovf_reg     <= ovf_next;
        end
    end

    wgm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (txt_fin),
        .push_data (buf_data),
        .ready     (buf_ready),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (m_tdata[0])
    );

    assign s_tready     = buf_ready;
    assign m_tdata[7:1] = '0;

`ifndef NO_ASSERTIONS
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (raw_cnt_reg == CNT_W'(PATTERN_DEPTH)))
        else $error("overflow flag set with store not full");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        raw_cnt_reg <= CNT_W'(PATTERN_DEPTH))
        else $error("pattern byte count beyond store depth");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
        txt_fin |=> m_tvalid)
        else $error("last text byte gave no result");
`endif

endmodule

// ===== rtl/core/wgm_cell.sv =====
// One pattern position of the matcher: stored byte, valid flag, active bit.
// Depends on wgm_pkg.
module wgm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wgm_pkg::wgm_ctrl_t        ctrl,
    input  logic [wgm_pkg::SYM_W-1:0] sym_in,     // from right neighbor
    input  logic                      vld_in,     // from right neighbor
    input  wgm_pkg::wgm_link_t        prev_link,  // from left neighbor
    output wgm_pkg::wgm_link_t        link,
    output logic [wgm_pkg::SYM_W-1:0] sym_out
);
    import wgm_pkg::*;

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    logic             vld_reg;
    logic             vld_next;
    logic             act_reg;
    logic             act_next;
    logic             star;
    logic             star_next;
    logic             hit;
    logic             pre;
    logic             start_next;

    assign star      = (sym_reg == SYM_ANY_RUN);
    assign hit       = (sym_reg == SYM_ANY_ONE) || (sym_reg == ctrl.sym);
    assign pre       = (act_reg & vld_reg & star) | prev_link.adv;

    assign sym_next  = ctrl.shift ? sym_in : sym_reg;
    assign vld_next  = ctrl.shift ? vld_in : vld_reg;
    assign star_next = (sym_next == SYM_ANY_RUN);
    assign start_next = vld_next & ~prev_link.vld_nx;

    // Stars never sit next to each other, so closure is one neighbor hop
    always_comb
    begin
        priority if (ctrl.rearm)
        begin
            act_next = start_next | (prev_link.st_nx & prev_link.starv_nx);
        end
        else if (ctrl.step)
        begin
            act_next = pre | (prev_link.pre & prev_link.starv);
        end
        else
        begin
            act_next = act_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            act_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg <= sym_next;
    end

    assign link.vld      = vld_reg;
    assign link.adv      = act_reg & vld_reg & ~star & hit;
    assign link.pre      = pre;
    assign link.starv    = vld_reg & star;
    assign link.vld_nx   = vld_next;
    assign link.st_nx    = start_next;
    assign link.starv_nx = vld_next & star_next;
    assign sym_out       = sym_reg;

endmodule

// ===== rtl/core/wgm_out_buf.sv =====
// Two-entry result buffer (output register plus skid stage).
// Depends on wgm_pkg.
module wgm_out_buf (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  logic push_data,
    output logic ready,
    output logic m_valid,
    input  logic m_ready,
    output logic m_data
);
    import wgm_pkg::*;

    logic main_v_reg;
    logic main_v_next;
    logic main_d_reg;
    logic main_d_next;
    logic skid_v_reg;
    logic skid_v_next;
    logic skid_d_reg;
    logic skid_d_next;
    logic pop;

    assign pop = main_v_reg & m_ready;

    always_comb
    begin
        main_v_next = main_v_reg;
        main_d_next = main_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (skid_v_reg)
        begin
            if (pop)
            begin
                main_d_next = skid_d_reg;
                skid_v_next = 1'b0;
            end
        end
        else if (push && main_v_reg && !pop)
        begin
            skid_v_next = 1'b1;
            skid_d_next = push_data;
        end
        else if (push)
        begin
            main_v_next = 1'b1;
            main_d_next = push_data;
        end
        else if (pop)
        begin
            main_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            main_v_reg <= main_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_d_reg <= main_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign ready   = ~skid_v_reg;
    assign m_valid = main_v_reg;
    assign m_data  = main_d_reg;

endmodule

// ===== tb/tb_wildcard_glob_matcher.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for wildcard_glob_matcher: a handshake-level glob predictor
// and random stalls on both stream sides. Depends on wgm_pkg and the matcher RTL.
module tb_wildcard_glob_matcher;

    import wgm_pkg::*;

    localparam int DEPTH      = PATTERN_DEPTH_DEF;
    localparam int RAND_REQS  = 1000;
    localparam int TAIL_CYC   = 20;
    localparam int CYCLE_CAP  = 400000;

    // One request on the input stream
    typedef struct packed {
        logic       mode;
        logic [7:0] sym;
        logic       last;
    } req_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] symbol
    logic       s_tuser  = 1'b0;   // [0] mode
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] matched, [7:1] zero

    wildcard_glob_matcher dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Glob predictor: its own copy of the pattern and of the live set.
    // live_pos[p] = 1 means the first p pattern bytes match the text so far.
    // ------------------------------------------------------------------
    logic [7:0]     pat_mem [DEPTH];
    int             pat_len    = 0;
    bit             pat_closed = 1'b0;
    bit             pat_ovf    = 1'b0;
    logic [DEPTH:0] live_pos   = (DEPTH+1)'(1);
    bit             match_q [$];     // predicted matched flags, oldest first

    int errors = 0;
    int cycles = 0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
            pat_mem[i] = 8'h00;
    end

    // A live star also makes the position after it live (empty run).
    // One forward pass is enough since runs of stars chain left to right.
    function automatic void close_stars(inout logic [DEPTH:0] v);
        for (int p = 0; p < pat_len; p++)
            if (v[p] && pat_mem[p] == SYM_ANY_RUN)
                v[p+1] = 1'b1;
    endfunction

    function automatic void rearm_live();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        close_stars(live_pos);
    endfunction

    function automatic void predict_req(input req_t r);
        logic [DEPTH:0] nxt;
        if (r.mode == MODE_PATTERN)
        begin
            // first byte after a closed pattern starts a fresh one
            if (pat_closed)
            begin
                pat_len    = 0;
                pat_ovf    = 1'b0;
                pat_closed = 1'b0;
            end
            if (pat_len < DEPTH)
            begin
                pat_mem[pat_len] = r.sym;
                pat_len++;
            end
            else
                pat_ovf = 1'b1;   // excess byte dropped, no match from now on
            if (r.last)
                pat_closed = 1'b1;
            rearm_live();
        end
        else
        begin
            nxt = '0;
            for (int p = 0; p < pat_len; p++)
            begin
                if (live_pos[p])
                begin
                    if (pat_mem[p] == SYM_ANY_RUN)
                        nxt[p] = 1'b1;              // star swallows the byte
                    else if (pat_mem[p] == SYM_ANY_ONE || pat_mem[p] == r.sym)
                        nxt[p+1] = 1'b1;
                end
            end
            close_stars(nxt);
            live_pos = nxt;
            if (r.last)
            begin
                match_q.insert(match_q.size(), live_pos[pat_len] && !pat_ovf);
                rearm_live();
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Wait draws: a random wait per request or result, with occasional calm stretches
    // of back-to-back traffic.
    // ------------------------------------------------------------------
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents requests from req_q, predicts at each handshake.
    // ------------------------------------------------------------------
    req_t req_q [$];
    req_t drv_next;
    int   drv_gap  = 0;
    int   drv_calm = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= MODE_PATTERN;
            s_tlast  <= 1'b0;
            drv_gap  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_req('{mode: s_tuser, sym: s_tdata, last: s_tlast});
            // slot is free after this edge: idle out the gap or load next
            if (!s_tvalid || s_tready)
            begin
                if (drv_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    drv_gap  <= drv_gap - 1;
                end
                else if (req_q.size() > 0)
                begin
                    drv_next = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= drv_next.sym;
                    s_tuser  <= drv_next.mode;
                    s_tlast  <= drv_next.last;
                    drv_gap  <= draw_wait(drv_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, checks every result against match_q.
    // ------------------------------------------------------------------
    int  mon_wait = 0;
    int  mon_calm = 0;
    int  mon_w;
    bit  mon_exp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            mon_wait <= 0;
        end
        else
        begin
            mon_w = mon_wait;
            if (m_tvalid && m_tready)
            begin
                if (match_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual matched=%0b",
                             $time, m_tdata[0]);
                end
                else
                begin
                    mon_exp = match_q.pop_front();
                    if (m_tdata[0] !== mon_exp)
                    begin
                        errors++;
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, mon_exp, m_tdata[0]);
                    end
                end
                mon_w = draw_wait(mon_calm);
            end
            if (mon_w > 0)
            begin
                m_tready <= 1'b0;
                mon_wait <= mon_w - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                mon_wait <= 0;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    int         n_queued = 0;
    logic [7:0] pat_buf [$];
    logic [7:0] txt_buf [$];

    task automatic push_req(input logic mode, input logic [7:0] sym, input logic last);
        req_t r;
        r.mode = mode;
        r.sym  = sym;
        r.last = last;
        req_q.insert(req_q.size(), r);
        n_queued++;
    endtask

    // pattern bytes lean on wildcards and a tiny alphabet so texts hit often
    function automatic logic [7:0] pick_pat_sym();
        int r;
        r = $urandom_range(0, 15);
        if (r < 4)
            return SYM_ANY_RUN;
        if (r < 6)
            return SYM_ANY_ONE;
        if (r == 6)
            return 8'($urandom_range(0, 255));
        return 8'("a" + $urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] pick_txt_sym();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'("a" + $urandom_range(0, 2));
    endfunction

    // Load a closed pattern: mostly short, now and then near or past the store depth
    task automatic gen_pattern();
        int len;
        pat_buf.delete();
        if ($urandom_range(0, 39) == 0)
            len = $urandom_range(DEPTH - 8, DEPTH + 12);
        else
            len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            pat_buf.insert(pat_buf.size(), pick_pat_sym());
        for (int i = 0; i < len; i++)
            push_req(MODE_PATTERN, pat_buf[i], i == len - 1);
    endtask

    // Text either derived from the pattern (likely match, maybe mutated)
    // or free random; never empty.
    task automatic gen_text();
        int n;
        int k;
        txt_buf.delete();
        if ($urandom_range(0, 1) == 0)
        begin
            foreach (pat_buf[i])
            begin
                if (pat_buf[i] == SYM_ANY_RUN)
                begin
                    n = $urandom_range(0, 3);
                    for (int j = 0; j < n; j++)
                        txt_buf.insert(txt_buf.size(), pick_txt_sym());
                end
                else if (pat_buf[i] == SYM_ANY_ONE)
                    txt_buf.insert(txt_buf.size(), pick_txt_sym());
                else
                    txt_buf.insert(txt_buf.size(), pat_buf[i]);
            end
            if (txt_buf.size() > 0 && $urandom_range(0, 3) == 0)
            begin
                k = $urandom_range(0, txt_buf.size() - 1);
                txt_buf[k] = pick_txt_sym();
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (int j = 0; j < n; j++)
                txt_buf.insert(txt_buf.size(), pick_txt_sym());
        end
        if (txt_buf.size() == 0)
            txt_buf.insert(txt_buf.size(), pick_txt_sym());
        foreach (txt_buf[i])
            push_req(MODE_TEXT, txt_buf[i], i == txt_buf.size() - 1);
    endtask

    // Unstructured requests: random mode, byte and last flag
    task automatic gen_noise();
        int n;
        n = $urandom_range(1, 5);
        for (int j = 0; j < n; j++)
            push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int n_txt;
        int base;

        // --- directed part ---
        // text with no pattern loaded: empty pattern never matches
        push_req(MODE_TEXT, "x", 1'b1);
        // open pattern "a*", text matched against the bytes so far
        push_req(MODE_PATTERN, "a", 1'b0);
        push_req(MODE_PATTERN, SYM_ANY_RUN, 1'b0);
        push_req(MODE_TEXT, "a", 1'b1);
        // closing byte extends the open pattern to "a*?"
        push_req(MODE_PATTERN, SYM_ANY_ONE, 1'b1);
        push_req(MODE_TEXT, "a", 1'b0);
        push_req(MODE_TEXT, "b", 1'b1);
        push_req(MODE_TEXT, "a", 1'b1);
        push_req(MODE_TEXT, "a", 1'b0);
        push_req(MODE_TEXT, "c", 1'b0);
        push_req(MODE_TEXT, "c", 1'b1);
        // byte extremes as literals; new pattern after a closed one
        push_req(MODE_PATTERN, 8'hFF, 1'b0);
        push_req(MODE_PATTERN, 8'h00, 1'b1);
        push_req(MODE_TEXT, 8'hFF, 1'b0);
        push_req(MODE_TEXT, 8'h00, 1'b1);
        push_req(MODE_TEXT, 8'h00, 1'b0);
        push_req(MODE_TEXT, 8'hFF, 1'b1);
        // lone star matches anything, wildcard bytes in the text too
        push_req(MODE_PATTERN, SYM_ANY_RUN, 1'b1);
        push_req(MODE_TEXT, 8'h7E, 1'b0);
        push_req(MODE_TEXT, SYM_ANY_RUN, 1'b1);
        // text abandoned mid-way by a pattern byte (no result for it)
        push_req(MODE_TEXT, "a", 1'b0);
        push_req(MODE_PATTERN, SYM_ANY_ONE, 1'b1);
        push_req(MODE_TEXT, SYM_ANY_ONE, 1'b1);
        push_req(MODE_TEXT, "a", 1'b0);
        push_req(MODE_TEXT, "b", 1'b1);

        // --- random part: mostly pattern + texts, some noise ---
        base = n_queued;
        while (n_queued - base < RAND_REQS)
        begin
            if ($urandom_range(0, 6) == 0)
                gen_noise();
            else
            begin
                gen_pattern();
                n_txt = (pat_buf.size() > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                for (int t = 0; t < n_txt; t++)
                    gen_text();
            end
        end

        // single reset at the start
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain: everything sent and every prediction answered
        @(negedge clk);
        while (req_q.size() > 0 || s_tvalid || match_q.size() > 0)
            @(negedge clk);
        // let any stray result surface
        repeat (TAIL_CYC) @(negedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
